[design/next_fit_block_allocator_defines.svh]
// Assertion macros for the next-fit block allocator.
`ifndef NEXT_FIT_BLOCK_ALLOCATOR_DEFINES_SVH
`define NEXT_FIT_BLOCK_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset.
`define NFBA_ASSERT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define NFBA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define NFBA_ASSERT(label, clk, rst, ante, cons, msg)

`define NFBA_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

[design/nfba_pkg.sv]
// Shared constants and types for the next-fit block allocator.
`timescale 1ns / 1ps

package nfba_pkg;

   // default table geometry
   localparam int MAX_BLOCKS_DEF = 16;
   localparam int SIZE_BITS_DEF  = 16;

   // fixed field widths
   localparam int CMD_W    = 1;
   localparam int LIDX_W   = 4;
   localparam int AMOUNT_W = 16;
   localparam int CHOSEN_W = 4;
   localparam int BC_W     = 5;

   // command codes
   localparam logic [CMD_W-1:0] CMD_LOAD  = 1'b0;
   localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b1;

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_BLOCK_COUNT = 1'b0;   // word index taken from paddr[2]
   localparam logic [BC_W-1:0] BLOCK_COUNT_RESET = 5'd16;

   // controller to datapath commands
   typedef struct packed {
      logic load;       // write one table entry from the input item
      logic start;      // latch request, set scan pointer
      logic issue;      // read table at scan pointer and advance it
      logic check;      // compare the entry read last cycle
      logic out_load;   // move result into the output register
   } dp_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic hit;        // entry read last cycle fits the request
      logic last;       // this compare is the last of the lap
   } dp_sts_type;

endpackage

[design/nfba_req_if.sv]
// Input item channel of the next-fit block allocator.
`timescale 1ns / 1ps

interface nfba_req_if;
   import nfba_pkg::*;

   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    command;
   logic [LIDX_W-1:0]   load_index;
   logic [AMOUNT_W-1:0] amount;

   modport source (output valid, command, load_index, amount, input ready);
   modport sink   (input valid, command, load_index, amount, output ready);
endinterface

[design/nfba_rsp_if.sv]
// Result item channel of the next-fit block allocator.
`timescale 1ns / 1ps

interface nfba_rsp_if;
   import nfba_pkg::*;

   logic                valid;
   logic                ready;
   logic                granted;
   logic [CHOSEN_W-1:0] chosen_block;

   modport source (output valid, granted, chosen_block, input ready);
   modport sink   (input valid, granted, chosen_block, output ready);
endinterface

[design/nfba_csr.sv]
// Configuration register file of the next-fit block allocator.
`timescale 1ns / 1ps

module nfba_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [nfba_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [nfba_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [nfba_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready,
   output logic [nfba_pkg::BC_W-1:0]       block_count
);
   import nfba_pkg::*;

   logic [BC_W-1:0] block_count_ff;
   logic            wr_en;

   // access phase write, no wait states
   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_BLOCK_COUNT);

   always_ff @(posedge clock) begin
      if (reset) begin
         block_count_ff <= BLOCK_COUNT_RESET;
      end else if (wr_en) begin
         block_count_ff <= pwdata[BC_W-1:0];
      end
   end

   // read back
   always_comb begin
      prdata = '0;
      if (paddr[2] == REG_BLOCK_COUNT) begin
         prdata = CSR_DATA_W'(block_count_ff);
      end
   end

   assign block_count = block_count_ff;
endmodule

[design/nfba_ctrl.sv]
// Sequencing controller of the next-fit block allocator.
`timescale 1ns / 1ps

module nfba_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic [nfba_pkg::CMD_W-1:0] req_command,
   output logic                       req_ready,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output nfba_pkg::dp_cmd_type       cmd,
   input  nfba_pkg::dp_sts_type       sts
);
   import nfba_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PRIME,
      ST_SCAN,
      ST_DONE
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           req_fire;
   logic           out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // datapath commands
   always_comb begin
      cmd          = '0;
      cmd.load     = req_fire && (req_command == CMD_LOAD);
      cmd.start    = req_fire && (req_command == CMD_ALLOC);
      cmd.issue    = (state_ff == ST_PRIME) || (state_ff == ST_SCAN);
      cmd.check    = (state_ff == ST_SCAN);
      cmd.out_load = (state_ff == ST_DONE) && out_free;
   end

   // next state and output valid
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (cmd.start) begin
               state_in = ST_PRIME;
            end
         end
         ST_PRIME: begin
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (sts.hit || sts.last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
endmodule

[design/nfba_dp.sv]
// Block table, scan pointer and result registers of the next-fit block allocator.
`timescale 1ns / 1ps

module nfba_dp #(
   parameter int MAX_BLOCKS = nfba_pkg::MAX_BLOCKS_DEF,
   parameter int SIZE_BITS  = nfba_pkg::SIZE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  nfba_pkg::dp_cmd_type          cmd,
   output nfba_pkg::dp_sts_type          sts,
   input  logic [nfba_pkg::BC_W-1:0]     block_count,
   input  logic [nfba_pkg::LIDX_W-1:0]   load_index,
   input  logic [nfba_pkg::AMOUNT_W-1:0] amount,
   output logic                          rsp_granted,
   output logic [nfba_pkg::CHOSEN_W-1:0] rsp_chosen_block
);
   import nfba_pkg::*;

   localparam int IDX_W = $clog2(MAX_BLOCKS);
   localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
   localparam logic [31:0] SIZE_MASK = 32'hFFFF_FFFF >> (32 - SIZE_BITS);

   // table memory, valid bits stand for the cleared reset value
   logic [SIZE_BITS-1:0]  mem [MAX_BLOCKS];
   logic [MAX_BLOCKS-1:0] valid_ff;
   logic [SIZE_BITS-1:0]  rd_data_ff;
   logic                  rd_vld_ff;

   logic [IDX_W-1:0]    rover_ff;
   logic [IDX_W-1:0]    issue_pos_ff;
   logic [IDX_W-1:0]    data_pos_ff;
   logic [IDX_W-1:0]    cmp_cnt_ff;
   logic [AMOUNT_W-1:0] amount_ff;
   logic                res_granted_ff;
   logic [IDX_W-1:0]    res_block_ff;
   logic                rsp_granted_ff;
   logic [CHOSEN_W-1:0] rsp_block_ff;

   logic [31:0]          bc_ext;
   logic [31:0]          eff32;
   logic [CNT_W-1:0]     count;
   logic [IDX_W-1:0]     start_pos;
   logic [CNT_W-1:0]     pos_inc;
   logic [IDX_W-1:0]     next_pos;
   logic [SIZE_BITS-1:0] data_eff;
   logic                 hit;
   logic                 last;
   logic [31:0]          amt_ext;
   logic [SIZE_BITS-1:0] load_val;
   logic                 load_ok;
   logic                 we;
   logic [IDX_W-1:0]     wa;
   logic [SIZE_BITS-1:0] wd;

   // effective block count: zero acts as one, clamp at table size
   assign bc_ext = 32'(block_count);
   always_comb begin
      if (bc_ext == 32'd0) begin
         eff32 = 32'd1;
      end else if (bc_ext > 32'(MAX_BLOCKS)) begin
         eff32 = 32'(MAX_BLOCKS);
      end else begin
         eff32 = bc_ext;
      end
   end
   assign count = CNT_W'(eff32);

   // scan start and circular advance
   assign start_pos = (CNT_W'(rover_ff) < count) ? rover_ff : '0;
   assign pos_inc   = CNT_W'(issue_pos_ff) + CNT_W'(1);
   assign next_pos  = (pos_inc >= count) ? '0 : IDX_W'(pos_inc);

   // compare stage on the registered read
   assign data_eff = rd_vld_ff ? rd_data_ff : '0;
   assign hit      = 32'(data_eff) >= 32'(amount_ff);
   assign last     = CNT_W'(cmp_cnt_ff) == (count - CNT_W'(1));
   assign sts.hit  = hit;
   assign sts.last = last;

   // load value saturates to the entry width
   assign amt_ext  = 32'(amount);
   assign load_val = SIZE_BITS'((amt_ext > SIZE_MASK) ? SIZE_MASK : amt_ext);
   assign load_ok  = cmd.load && (32'(load_index) < 32'(MAX_BLOCKS));

   // single write port: load or shrink of the granted block
   assign we = load_ok || (cmd.check && hit);
   assign wa = cmd.load ? IDX_W'(load_index) : data_pos_ff;
   assign wd = cmd.load ? load_val : SIZE_BITS'(32'(data_eff) - 32'(amount_ff));

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      rd_data_ff <= mem[issue_pos_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= valid_ff[issue_pos_ff];
         if (we) begin
            valid_ff[wa] <= 1'b1;
         end
      end
   end

   // rover moves only on a grant
   always_ff @(posedge clock) begin
      if (reset) begin
         rover_ff <= '0;
      end else if (cmd.check && hit) begin
         rover_ff <= data_pos_ff;
      end
   end

   // scan pointer, compare count and latched request
   always_ff @(posedge clock) begin
      data_pos_ff <= issue_pos_ff;
      if (cmd.start) begin
         issue_pos_ff <= start_pos;
         cmp_cnt_ff   <= '0;
         amount_ff    <= amount;
      end else begin
         if (cmd.issue) begin
            issue_pos_ff <= next_pos;
         end
         if (cmd.check && !hit) begin
            cmp_cnt_ff <= cmp_cnt_ff + IDX_W'(1);
         end
      end
   end

   // result capture and output register
   always_ff @(posedge clock) begin
      if (cmd.check && hit) begin
         res_granted_ff <= 1'b1;
         res_block_ff   <= data_pos_ff;
      end else if (cmd.check && last) begin
         res_granted_ff <= 1'b0;
         res_block_ff   <= '0;
      end
      if (cmd.out_load) begin
         rsp_granted_ff <= res_granted_ff;
         rsp_block_ff   <= CHOSEN_W'(res_block_ff);
      end
   end

   assign rsp_granted      = rsp_granted_ff;
   assign rsp_chosen_block = rsp_block_ff;
endmodule

[design/next_fit_block_allocator.sv]
// Top level of the next-fit block allocator.
//
//   channel  direction  handshake          payload
//   req      in         valid/ready        command, load_index, amount
//   rsp      out        valid/ready        granted, chosen_block
//   csr      in         APB psel/penable   block_count at byte address 0
//
// A load item gives no result.
// An allocate item runs through a prime step, a scan that examines k blocks,
// where k is 1 to the effective block count, and a done step before the next
// accept; the scan reads one entry per cycle and compares it from a register.
// Reset clears the table at once through per-entry valid bits.
// A finished result sits in the output register; if it is still untaken
// when the next result is ready, the block holds that result and stalls input.
`timescale 1ns / 1ps
`include "next_fit_block_allocator_defines.svh"

module next_fit_block_allocator #(
   parameter int MAX_BLOCKS = nfba_pkg::MAX_BLOCKS_DEF,
   parameter int SIZE_BITS  = nfba_pkg::SIZE_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   nfba_req_if.sink                        req_chan,
   nfba_rsp_if.source                      rsp_chan,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [nfba_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [nfba_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [nfba_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import nfba_pkg::*;

   dp_cmd_type      dp_cmd;
   dp_sts_type      dp_sts;
   logic [BC_W-1:0] block_count;

   // configuration registers
   nfba_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .psel        (csr_psel),
      .penable     (csr_penable),
      .pwrite      (csr_pwrite),
      .paddr       (csr_paddr),
      .pwdata      (csr_pwdata),
      .prdata      (csr_prdata),
      .pready      (csr_pready),
      .block_count (block_count)
   );

   // sequencer
   nfba_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_chan.valid),
      .req_command (req_chan.command),
      .req_ready   (req_chan.ready),
      .rsp_valid   (rsp_chan.valid),
      .rsp_ready   (rsp_chan.ready),
      .cmd         (dp_cmd),
      .sts         (dp_sts)
   );

   // table and scan datapath
   nfba_dp #(
      .MAX_BLOCKS (MAX_BLOCKS),
      .SIZE_BITS  (SIZE_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (dp_cmd),
      .sts              (dp_sts),
      .block_count      (block_count),
      .load_index       (req_chan.load_index),
      .amount           (req_chan.amount),
      .rsp_granted      (rsp_chan.granted),
      .rsp_chosen_block (rsp_chan.chosen_block)
   );

   // no input item is taken while the table is being scanned
   `NFBA_ASSERT(a_no_accept_in_scan, clock, reset, dp_cmd.issue, !req_chan.ready, "item accepted during scan")

   // the output register is only reloaded once the old result has left
   `NFBA_ASSERT(a_out_slot_free, clock, reset, dp_cmd.out_load, (!rsp_chan.valid || rsp_chan.ready), "result overwritten")

   // a refused request always reports block zero
   `NFBA_ASSERT(a_refuse_block_zero, clock, reset, (rsp_chan.valid && !rsp_chan.granted), (rsp_chan.chosen_block == '0), "refusal with nonzero block")

   // a result register load is followed by a valid result
   `NFBA_ASSERT_NEXT(a_result_shown, clock, reset, dp_cmd.out_load, rsp_chan.valid, "result not presented")

endmodule
